// ===== design/ieu_pkg.sv =====
`timescale 1ns / 1ps
package ieu_pkg;

   localparam int unsigned XLEN = 32;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned DIV_LATENCY = 32;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,
      OP_SUB  = 5'd1,
      OP_MUL  = 5'd2,
      OP_MULU = 5'd3,
      OP_DIV  = 5'd4,
      OP_DIVU = 5'd5,
      OP_XOR  = 5'd6,
      OP_NEG  = 5'd7,
      OP_REM  = 5'd8,
      OP_REMU = 5'd9,
      OP_EQ   = 5'd10,
      OP_GE   = 5'd11,
      OP_GT   = 5'd12,
      OP_LE   = 5'd13,
      OP_LT   = 5'd14,
      OP_NE   = 5'd15,
      OP_PASS = 5'd16
   } op_type;

   typedef enum logic [1:0] {
      CLS_SIMPLE = 2'd0,
      CLS_MUL    = 2'd1,
      CLS_DIV    = 2'd2
   } class_type;

   // Decoded item handed from the front end to the back end.
   typedef struct packed {
      class_type         cls;
      logic              sgn;
      logic              want_rem;
      logic              div_zero;
      logic              div_ovf;
      logic [XLEN-1:0]   op_a;
      logic [XLEN-1:0]   op_b;
      logic [XLEN-1:0]   simple_lo;
   } issue_type;

   typedef struct packed {
      logic [XLEN-1:0] low_word;
      logic [XLEN-1:0] high_word;
      logic            divide_by_zero;
   } result_type;

   typedef struct packed {
      logic [4:0]       mode;
      logic [XLEN-1:0]  operand_a;
      logic [XLEN-1:0]  operand_b;
   } request_type;

endpackage

// ===== design/ieu_if.sv =====
`timescale 1ns / 1ps
interface ieu_req_if;
   logic                 valid;
   logic                 ready;
   ieu_pkg::request_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ieu_rsp_if;
   logic                valid;
   logic                ready;
   ieu_pkg::result_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/ieu_front.sv =====
`timescale 1ns / 1ps
module ieu_front (
   input  logic                clock,
   input  logic                reset,
   ieu_req_if.sink             req,
   output logic                issue_valid,
   output ieu_pkg::issue_type  issue_data,
   input  logic                issue_ready
);

   logic                q_full;
   logic                push;
   logic                pop;
   logic [ieu_pkg::QUEUE_PTR_W:0]   count_ff, count_in;
   logic [ieu_pkg::QUEUE_PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   ieu_pkg::issue_type  slot_ff [ieu_pkg::QUEUE_DEPTH];
   ieu_pkg::issue_type  dec;
   logic [4:0]          m;
   logic [ieu_pkg::XLEN-1:0] a, b;
   logic                lt_s, eq;

   assign m = req.payload.mode;
   assign a = req.payload.operand_a;
   assign b = req.payload.operand_b;
   assign eq = (a == b);
   assign lt_s = ($signed(a) < $signed(b));

   always_comb begin
      dec = '0;
      dec.op_a = a;
      dec.op_b = b;
      dec.div_zero = (b == '0);
      dec.div_ovf = (a == {1'b1, {(ieu_pkg::XLEN-1){1'b0}}}) && (b == '1);
      case (m)
         ieu_pkg::OP_ADD:  dec.simple_lo = a + b;
         ieu_pkg::OP_SUB:  dec.simple_lo = a - b;
         ieu_pkg::OP_XOR:  dec.simple_lo = a ^ b;
         ieu_pkg::OP_NEG:  dec.simple_lo = '0 - a;
         ieu_pkg::OP_PASS: dec.simple_lo = a;
         ieu_pkg::OP_EQ:   dec.simple_lo = {31'd0, eq};
         ieu_pkg::OP_NE:   dec.simple_lo = {31'd0, !eq};
         ieu_pkg::OP_LT:   dec.simple_lo = {31'd0, lt_s};
         ieu_pkg::OP_GE:   dec.simple_lo = {31'd0, !lt_s};
         ieu_pkg::OP_GT:   dec.simple_lo = {31'd0, !lt_s && !eq};
         ieu_pkg::OP_LE:   dec.simple_lo = {31'd0, lt_s || eq};
         ieu_pkg::OP_MUL: begin
            dec.cls = ieu_pkg::CLS_MUL;
            dec.sgn = 1'b1;
         end
         ieu_pkg::OP_MULU: dec.cls = ieu_pkg::CLS_MUL;
         ieu_pkg::OP_DIV: begin
            dec.cls = ieu_pkg::CLS_DIV;
            dec.sgn = 1'b1;
         end
         ieu_pkg::OP_DIVU: dec.cls = ieu_pkg::CLS_DIV;
         ieu_pkg::OP_REM: begin
            dec.cls = ieu_pkg::CLS_DIV;
            dec.sgn = 1'b1;
            dec.want_rem = 1'b1;
         end
         ieu_pkg::OP_REMU: begin
            dec.cls = ieu_pkg::CLS_DIV;
            dec.want_rem = 1'b1;
         end
         default: dec.simple_lo = '0;
      endcase
      if (dec.cls != ieu_pkg::CLS_DIV) begin
         dec.div_zero = 1'b0;
         dec.div_ovf = 1'b0;
      end
      if (!dec.sgn) begin
         dec.div_ovf = 1'b0;
      end
   end

   assign q_full = (count_ff == (ieu_pkg::QUEUE_PTR_W+1)'(ieu_pkg::QUEUE_DEPTH));
   assign req.ready = !q_full;
   assign push = req.valid && !q_full;
   assign issue_valid = (count_ff != '0);
   assign issue_data = slot_ff[rptr_ff];
   assign pop = issue_valid && issue_ready;

   always_comb begin
      wptr_in = wptr_ff + (ieu_pkg::QUEUE_PTR_W)'(1);
      rptr_in = rptr_ff + (ieu_pkg::QUEUE_PTR_W)'(1);
      count_in = count_ff + (ieu_pkg::QUEUE_PTR_W+1)'(push)
                 - (ieu_pkg::QUEUE_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wptr_ff <= wptr_in;
         if (pop) rptr_ff <= rptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= dec;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (ieu_pkg::QUEUE_PTR_W+1)'(ieu_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push) else $error("push into full queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance");

endmodule

// ===== design/ieu_back.sv =====
`timescale 1ns / 1ps
module ieu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                issue_valid,
   input  ieu_pkg::issue_type  issue_data,
   output logic                issue_ready,
   ieu_rsp_if.source           rsp
);
   localparam int unsigned W = ieu_pkg::XLEN;
   localparam int unsigned L = ieu_pkg::DIV_LATENCY;

   // Stage pipeline: stage 0 prepares, stages 1..L each do one restoring
   // divide step and one of them also does the multiply, then output.
   typedef struct packed {
      logic              valid;
      ieu_pkg::class_type cls;
      logic              want_rem;
      logic              div_zero;
      logic              div_ovf;
      logic              neg_q;
      logic              neg_r;
      logic [W-1:0]      a;
      logic [W-1:0]      lo;
      logic [W-1:0]      rem;
      logic [W-1:0]      quo;
      logic [W-1:0]      dvs;
      logic [2*W-1:0]    prod;
   } stage_type;

   stage_type st_ff [L+1];
   stage_type st_in [L+1];
   logic      advance;
   logic      out_valid_ff;
   ieu_pkg::result_type out_ff, out_in;
   logic      hold_valid_ff;
   ieu_pkg::result_type hold_ff;
   logic      last_ready;

   // The whole pipe moves when the output stage can take the last stage.
   assign last_ready = !out_valid_ff || !hold_valid_ff;
   assign advance = last_ready;
   assign issue_ready = advance;

   always_comb begin
      logic [W-1:0] aa, bb;
      logic         sa, sb;
      sa = issue_data.sgn && issue_data.op_a[W-1];
      sb = issue_data.sgn && issue_data.op_b[W-1];
      aa = sa ? '0 - issue_data.op_a : issue_data.op_a;
      bb = sb ? '0 - issue_data.op_b : issue_data.op_b;
      st_in[0] = '0;
      st_in[0].valid = issue_valid;
      st_in[0].cls = issue_data.cls;
      st_in[0].want_rem = issue_data.want_rem;
      st_in[0].div_zero = issue_data.div_zero;
      st_in[0].div_ovf = issue_data.div_ovf;
      st_in[0].neg_q = sa ^ sb;
      st_in[0].neg_r = sa;
      st_in[0].a = issue_data.op_a;
      st_in[0].lo = issue_data.simple_lo;
      st_in[0].quo = aa;
      st_in[0].dvs = bb;
      st_in[0].prod = {{W{sa ^ sb}}, {W{1'b0}}};
      // Stash the raw operands for the multiply in the product field.
      if (issue_data.cls == ieu_pkg::CLS_MUL) begin
         st_in[0].prod = {issue_data.op_a, issue_data.op_b};
         st_in[0].neg_q = issue_data.sgn;
      end
   end

   for (genvar s = 1; s <= L; s++) begin : g_step
      always_comb begin
         logic [W:0] trial;
         logic [W:0] shifted;
         st_in[s] = st_ff[s-1];
         shifted = {st_ff[s-1].rem, st_ff[s-1].quo[W-1]};
         trial = shifted - {1'b0, st_ff[s-1].dvs};
         if (st_ff[s-1].cls == ieu_pkg::CLS_DIV) begin
            if (!trial[W]) begin
               st_in[s].rem = trial[W-1:0];
               st_in[s].quo = {st_ff[s-1].quo[W-2:0], 1'b1};
            end else begin
               st_in[s].rem = shifted[W-1:0];
               st_in[s].quo = {st_ff[s-1].quo[W-2:0], 1'b0};
            end
         end
         if (s == 1 && st_ff[0].cls == ieu_pkg::CLS_MUL) begin
            if (st_ff[0].neg_q) begin
               st_in[s].prod = 64'($signed(st_ff[0].prod[2*W-1:W])
                                   * $signed(st_ff[0].prod[W-1:0]));
            end else begin
               st_in[s].prod = st_ff[0].prod[2*W-1:W] * st_ff[0].prod[W-1:0];
            end
         end
      end
   end

   always_comb begin
      stage_type t;
      logic [W-1:0] q, r;
      t = st_ff[L];
      q = t.neg_q ? '0 - t.quo : t.quo;
      r = t.neg_r ? '0 - t.rem : t.rem;
      out_in = '0;
      case (t.cls)
         ieu_pkg::CLS_MUL: begin
            out_in.low_word = t.prod[W-1:0];
            out_in.high_word = t.prod[2*W-1:W];
         end
         ieu_pkg::CLS_DIV: begin
            out_in.divide_by_zero = t.div_zero;
            if (t.div_zero) begin
               out_in.low_word = t.want_rem ? t.a : '1;
               out_in.high_word = t.want_rem ? '0 : t.a;
            end else if (t.div_ovf) begin
               out_in.low_word = t.want_rem ? '0 : {1'b1, {(W-1){1'b0}}};
            end else begin
               out_in.low_word = t.want_rem ? r : q;
               out_in.high_word = t.want_rem ? '0 : r;
            end
         end
         default: out_in.low_word = t.lo;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= L; i++) st_ff[i].valid <= 1'b0;
         out_valid_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            for (int i = 0; i <= L; i++) st_ff[i] <= st_in[i];
         end
         // Output register with a skid slot behind it.
         if (out_valid_ff && !rsp.ready) begin
            if (advance && st_ff[L].valid) hold_valid_ff <= 1'b1;
         end else if (hold_valid_ff) begin
            hold_valid_ff <= 1'b0;
            out_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= advance && st_ff[L].valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && !rsp.ready) begin
         if (advance && st_ff[L].valid) hold_ff <= out_in;
      end else if (hold_valid_ff) begin
         out_ff <= hold_ff;
      end else if (advance && st_ff[L].valid) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   a_hold_implies_out: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> out_valid_ff) else $error("skid full with empty output");
   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |=> out_valid_ff)
      else $error("result dropped under stall");
   a_no_adv_full: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && out_valid_ff) |-> !advance)
      else $error("pipe advanced with both output slots full");

endmodule

// ===== design/integer_execute_unit_hi_lo_top.sv =====
`timescale 1ns / 1ps
// Path: every operation passes through a queue slot, 33 pipeline stages and the
// output register; the 32-stage radix-2 divider is fully pipelined.
// Throughput: one item per cycle unless a stalled response fills the skid slot.
// Reset: synchronous, active high; clears the queue, pipe valids and output.
module integer_execute_unit_hi_lo_top (
   input  logic        clock,
   input  logic        reset,
   ieu_req_if.sink     req,
   ieu_rsp_if.source   rsp
);

   logic               issue_valid;
   logic               issue_ready;
   ieu_pkg::issue_type issue_data;

   ieu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .issue_valid (issue_valid),
      .issue_data  (issue_data),
      .issue_ready (issue_ready)
   );

   ieu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue_data  (issue_data),
      .issue_ready (issue_ready),
      .rsp         (rsp)
   );

endmodule
